[design/fde_pkg.sv]
// shared types and constants for the fat directory entry search block
// no dependencies; imported by every module of the block

package fde_pkg;

  typedef enum logic [1:0] {
    ST_SKIP  = 2'd0,
    ST_FOUND = 2'd1,
    ST_END   = 2'd2
  } status_t;

  // configuration register indexes
  localparam logic [7:0] REG_NAME_FIRST = 8'd0;
  localparam logic [7:0] REG_NAME_LAST  = 8'd1;
  localparam logic [7:0] REG_DATA_START = 8'd2;
  localparam logic [7:0] REG_CLUS_SECT  = 8'd3;

  // directory entry layout
  localparam logic [4:0] OFS_LEAD     = 5'h00;
  localparam logic [4:0] OFS_ATTR     = 5'h0b;
  localparam logic [4:0] OFS_CLUS_HI  = 5'h14;
  localparam logic [4:0] OFS_CLUS_LO  = 5'h1a;
  localparam logic [4:0] OFS_SIZE     = 5'h1c;
  localparam logic [4:0] OFS_LAST     = 5'h1f;
  localparam int         NAME_LEN     = 11;

  localparam logic [7:0] LEAD_END     = 8'h00;
  localparam logic [7:0] LEAD_DELETED = 8'he5;
  localparam logic [7:0] ATTR_MASK    = 8'h3f;
  localparam logic [7:0] ATTR_LFN     = 8'h0f;
  localparam logic [7:0] ATTR_HIDE    = 8'h02;
  localparam logic [7:0] ATTR_VOLUME  = 8'h08;

  localparam logic [31:0] FIRST_DATA_CLUSTER = 32'd2;

  // one classified directory entry
  typedef struct packed {
    status_t     status;
    logic [31:0] cluster;
    logic [31:0] size;
  } entry_t;

endpackage

[design/fde_front.sv]
// front end: assembles 32-byte directory entries, compares the 8.3 name
// and classifies each entry on its last byte; uses fde_pkg

module fde_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            accept,
  input  logic [7:0]      data_byte,
  input  logic            scan_begin,
  input  logic [63:0]     name_first_eight,
  input  logic [23:0]     name_last_three,
  output logic            push,
  output fde_pkg::entry_t entry
);
  import fde_pkg::*;

  logic [4:0]  offset_r, offset_nxt;
  logic [7:0]  lead_r, lead_nxt;
  logic        equal_r, equal_nxt;
  logic [7:0]  attr_r, attr_nxt;
  logic [31:0] cluster_r, cluster_nxt;
  logic [31:0] size_r, size_nxt;
  logic        finished_r, finished_nxt;

  logic [7:0]  name_bytes [NAME_LEN];
  logic [4:0]  pos;
  logic        eq_in;
  logic        active;
  logic [7:0]  wanted;
  logic        is_name;
  status_t     status;

  always_comb begin
    for (int i = 0; i < 8; i++) name_bytes[i] = name_first_eight[i*8 +: 8];
    for (int i = 0; i < 3; i++) name_bytes[8+i] = name_last_three[i*8 +: 8];
  end

  // scan_begin restarts the position and the compare flag
  assign pos     = scan_begin ? OFS_LEAD : offset_r;
  assign eq_in   = scan_begin ? 1'b1 : equal_r;
  assign active  = accept && !(finished_r && !scan_begin);
  assign is_name = pos < 5'(NAME_LEN);
  assign wanted  = is_name ? name_bytes[pos[3:0]] : 8'h00;

  // classification on the last byte; lead, attribute and name are complete
  always_comb begin
    if (lead_r == LEAD_END)
      status = ST_END;
    else if (lead_r == LEAD_DELETED)
      status = ST_SKIP;
    else if ((attr_r & ATTR_MASK) == ATTR_LFN || (attr_r & ATTR_HIDE) != 8'h00 ||
             (attr_r & ATTR_VOLUME) != 8'h00)
      status = ST_SKIP;
    else if (equal_r)
      status = ST_FOUND;
    else
      status = ST_SKIP;
  end

  always_comb begin
    offset_nxt   = offset_r;
    lead_nxt     = lead_r;
    equal_nxt    = equal_r;
    attr_nxt     = attr_r;
    cluster_nxt  = cluster_r;
    size_nxt     = size_r;
    finished_nxt = finished_r;
    if (accept && scan_begin) begin
      offset_nxt   = OFS_LEAD;
      equal_nxt    = 1'b1;
      finished_nxt = 1'b0;
    end
    if (active) begin
      equal_nxt = eq_in;
      if (pos == OFS_LEAD) begin
        lead_nxt  = data_byte;
        equal_nxt = 1'b1;
      end
      if (is_name && data_byte != wanted) equal_nxt = 1'b0;
      if (pos == OFS_ATTR) attr_nxt = data_byte;
      if (pos == OFS_CLUS_HI)        cluster_nxt[23:16] = data_byte;
      if (pos == OFS_CLUS_HI + 5'd1) cluster_nxt[31:24] = data_byte;
      if (pos == OFS_CLUS_LO)        cluster_nxt[7:0]   = data_byte;
      if (pos == OFS_CLUS_LO + 5'd1) cluster_nxt[15:8]  = data_byte;
      if (pos >= OFS_SIZE) size_nxt[(pos[1:0])*8 +: 8] = data_byte;
      offset_nxt = pos + 5'd1;
      if (pos == OFS_LAST && status != ST_SKIP) finished_nxt = 1'b1;
    end
  end

  assign push          = active && pos == OFS_LAST;
  assign entry.status  = status;
  assign entry.cluster = cluster_r;
  assign entry.size    = {data_byte, size_r[23:0]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r   <= 5'd0;
      lead_r     <= 8'd0;
      equal_r    <= 1'b1;
      attr_r     <= 8'd0;
      cluster_r  <= 32'd0;
      size_r     <= 32'd0;
      finished_r <= 1'b0;
    end else begin
      offset_r   <= offset_nxt;
      lead_r     <= lead_nxt;
      equal_r    <= equal_nxt;
      attr_r     <= attr_nxt;
      cluster_r  <= cluster_nxt;
      size_r     <= size_nxt;
      finished_r <= finished_nxt;
    end
  end

`ifndef SYNTHESIS
  a_push_wraps: assert property (@(posedge clk) disable iff (!rst_n)
    push |=> offset_r == OFS_LEAD)
    else $error("entry position did not wrap after last byte");

  a_done_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    push && entry.status != ST_SKIP |=> finished_r)
    else $error("scan not finished after found or end entry");
`endif

endmodule

[design/fde_queue.sv]
// short entry queue between the front and back ends
// register-based fifo of fde_pkg::entry_t

module fde_queue #(
  parameter int DEPTH = 4
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  fde_pkg::entry_t push_data,
  output logic            full,
  input  logic            pop,
  output fde_pkg::entry_t pop_data,
  output logic            empty
);
  import fde_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  entry_t        mem [DEPTH];
  logic [PW-1:0] wr_r, wr_nxt;
  logic [PW-1:0] rd_r, rd_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign full     = count_r == CW'(DEPTH);
  assign empty    = count_r == '0;
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem[rd_r];

  always_comb begin
    wr_nxt    = wr_r;
    rd_nxt    = rd_r;
    count_nxt = count_r;
    if (do_push) wr_nxt = (wr_r == PW'(DEPTH - 1)) ? '0 : wr_r + 1'b1;
    if (do_pop)  rd_nxt = (rd_r == PW'(DEPTH - 1)) ? '0 : rd_r + 1'b1;
    if (do_push && !do_pop) count_nxt = count_r + 1'b1;
    else if (do_pop && !do_push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r    <= '0;
      rd_r    <= '0;
      count_r <= '0;
    end else begin
      wr_r    <= wr_nxt;
      rd_r    <= rd_nxt;
      count_r <= count_nxt;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("entry pushed into full queue");
`endif

endmodule

[design/fde_back.sv]
// back end: turns a classified entry into a result, computing the first
// data sector over two stages; uses fde_pkg

module fde_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_empty,
  input  fde_pkg::entry_t q_data,
  output logic            q_pop,
  input  logic [31:0]     data_region_start,
  input  logic [7:0]      cluster_sectors,
  output logic            out_empty,
  input  logic            out_pop,
  output logic [1:0]      out_entry_status,
  output logic [31:0]     out_start_cluster,
  output logic [31:0]     out_start_sector,
  output logic [31:0]     out_byte_length
);
  import fde_pkg::*;

  logic        s1_v_r, s1_v_nxt;
  entry_t      s1_r;
  logic [31:0] prod_r;
  logic [39:0] prod_full;
  logic        out_v_r, out_v_nxt;
  logic        out_ready, s1_en;
  logic        found;

  assign out_ready = !out_v_r || out_pop;
  assign s1_en     = !s1_v_r || out_ready;
  assign q_pop     = s1_en && !q_empty;
  assign prod_full = (q_data.cluster - FIRST_DATA_CLUSTER) * cluster_sectors;
  assign found     = s1_r.status == ST_FOUND;
  assign out_empty = !out_v_r;

  always_comb begin
    s1_v_nxt  = s1_en ? !q_empty : s1_v_r;
    out_v_nxt = out_ready ? s1_v_r : out_v_r;
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_r   <= q_data;
      prod_r <= prod_full[31:0];
    end
    if (out_ready && s1_v_r) begin
      out_entry_status  <= s1_r.status;
      out_start_cluster <= found ? s1_r.cluster : 32'd0;
      out_start_sector  <= found ? data_region_start + prod_r : 32'd0;
      out_byte_length   <= found ? s1_r.size : 32'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

`ifndef SYNTHESIS
  a_zero_unless_found: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && out_entry_status != ST_FOUND |->
      out_start_cluster == 32'd0 && out_start_sector == 32'd0 &&
      out_byte_length == 32'd0)
    else $error("payload not cleared on non-match result");
`endif

endmodule

[design/fat_directory_entry_search.sv]
// fat 8.3 directory entry search: one result per 32-byte entry until a found or end entry
// path: an entry goes through the entry queue, the product stage and the output register
// throughput: one byte every cycle while in_full is low; in_full rises only when the
// entry queue holds QUEUE_DEPTH entries that the back end has not yet taken
// reset: synchronous active-low rst_n resets position, flags, queue and output valid;
// configuration returns to name zero, data start zero, one sector per cluster

module fat_directory_entry_search #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [7:0]  in_data_byte,
  input  logic        in_scan_begin,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [1:0]  out_entry_status,
  output logic [31:0] out_start_cluster,
  output logic [31:0] out_start_sector,
  output logic [31:0] out_byte_length,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [63:0] cfg_data
);
  import fde_pkg::*;

  logic [63:0] name_first_r;
  logic [23:0] name_last_r;
  logic [31:0] data_start_r;
  logic [7:0]  clus_sect_r;

  logic   accept;
  logic   f_push, q_full, q_empty, q_pop;
  entry_t f_entry, q_data;

  assign cfg_ready = 1'b1;
  assign accept    = in_push && !in_full;
  assign in_full   = q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      name_first_r <= 64'd0;
      name_last_r  <= 24'd0;
      data_start_r <= 32'd0;
      clus_sect_r  <= 8'd1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_NAME_FIRST: name_first_r <= cfg_data;
        REG_NAME_LAST:  name_last_r  <= cfg_data[23:0];
        REG_DATA_START: data_start_r <= cfg_data[31:0];
        REG_CLUS_SECT:  clus_sect_r  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  fde_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .accept           (accept),
    .data_byte        (in_data_byte),
    .scan_begin       (in_scan_begin),
    .name_first_eight (name_first_r),
    .name_last_three  (name_last_r),
    .push             (f_push),
    .entry            (f_entry)
  );

  fde_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (f_push),
    .push_data (f_entry),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_data),
    .empty     (q_empty)
  );

  fde_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_empty           (q_empty),
    .q_data            (q_data),
    .q_pop             (q_pop),
    .data_region_start (data_start_r),
    .cluster_sectors   (clus_sect_r),
    .out_empty         (out_empty),
    .out_pop           (out_pop),
    .out_entry_status  (out_entry_status),
    .out_start_cluster (out_start_cluster),
    .out_start_sector  (out_start_sector),
    .out_byte_length   (out_byte_length)
  );

endmodule
